### hdl/rational_arith_reduce_top_macros.svh
// Assertion macros shared by the rational arithmetic RTL.
`ifndef RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define RAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rar_pkg.sv
// Package with shared types and codes for the rational arithmetic block.
`timescale 1ns / 1ps
package rar_pkg;

  localparam int OUT_WIDTH = 33;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD_GO,
    S_GCD_WAIT,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_REDUCE,
    G_SHIFT
  } gcd_phase_t;

endpackage

### hdl/rar_gcd.sv
// Binary GCD unit: one shift or one subtract per cycle.
`timescale 1ns / 1ps
`include "rational_arith_reduce_top_macros.svh"
module rar_gcd import rar_pkg::*; #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x_in,
  input  logic [WIDTH-1:0] y_in,
  output logic             done,
  output logic [WIDTH-1:0] g
);

  localparam int KW = $clog2(WIDTH + 1);

  gcd_phase_t      phase;
  gcd_phase_t      phase_next;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [KW-1:0]    k;
  logic [WIDTH:0]   d_xy;
  logic [WIDTH-1:0] d_yx;
  logic             x_ge_y;

  // Shared subtractor pair for the odd/odd step
  assign d_xy   = {1'b0, x} - {1'b0, y};
  assign d_yx   = y - x;
  assign x_ge_y = !d_xy[WIDTH];

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      G_IDLE: begin
        if (start) phase_next = G_REDUCE;
      end
      G_REDUCE: begin
        if (x == '0) phase_next = G_SHIFT;
      end
      G_SHIFT: begin
        if (k == '0) phase_next = G_IDLE;
      end
      default: phase_next = G_IDLE;
    endcase
  end

  // Outputs: the result is y restored by the common power of two
  always_comb begin
    done = 1'b0;
    g    = y;
    case (phase)
      G_SHIFT: done = (k == '0);
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= G_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Reduce x and y; x reaches zero with the odd part of the gcd in y
  always_ff @(posedge clk) begin
    case (phase)
      G_IDLE: begin
        if (start) begin
          x <= x_in;
          y <= y_in;
          k <= '0;
        end
      end
      G_REDUCE: begin
        if (x != '0) begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x_ge_y) begin
            x <= d_xy[WIDTH-1:0];
          end else begin
            y <= d_yx;
          end
        end
      end
      G_SHIFT: begin
        if (k != '0) begin
          y <= {y[WIDTH-2:0], 1'b0};
          k <= k - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  `RAR_ASSERT_NOW(a_gcd_y_nonzero, phase == G_REDUCE, y != '0, "gcd: y reached zero")
  `RAR_ASSERT_NOW(a_gcd_x_cleared, phase == G_SHIFT, x == '0, "gcd: restore with x nonzero")

endmodule

### hdl/rar_div.sv
// Restoring serial divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`include "rational_arith_reduce_top_macros.svh"
module rar_div import rar_pkg::*; #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   sh;
  logic [WIDTH+1:0] diff;
  logic             ge;

  // Trial subtract of the divisor from the shifted remainder
  assign sh       = {rem, quo[WIDTH-1]};
  assign diff     = {1'b0, sh} - {2'b00, dsr};
  assign ge       = !diff[WIDTH+1];
  assign quotient = quo;

  // Control: count the steps, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], ge};
    end
  end

  `RAR_ASSERT_NOW(a_div_rem_below, busy, rem < dsr, "div: remainder not below divisor")

endmodule

### hdl/rational_arith_reduce_top.sv
// Top level: signed fraction add, subtract, multiply, divide with gcd reduction.
`timescale 1ns / 1ps
`include "rational_arith_reduce_top_macros.svh"
// Pulse start while busy is low to hand in one beat: operation and the fractions
// num_a/den_a and num_b/den_b. Exactly one result beat follows, shown for a single
// cycle with done high; the receiver cannot hold it off, so it must take it then.
// The result is reduced to lowest terms with signs kept as computed, so result_den
// may be negative. A zero input denominator gives error_code 1, a division by a
// zero fraction gives error_code 2; both with zero outputs, on the cycle right after
// the beat is taken. Otherwise the products (three for add/subtract, two for
// multiply/divide) share one multiplier, add/subtract then combine the cross
// products, the binary gcd loop runs (one shift or subtract per cycle), and the
// two exact divisions by the gcd run one after the other through one serial
// divider, one bit a cycle, at 2*VALUE_WIDTH+1 bits. busy stays high until done.
module rational_arith_reduce_top import rar_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic signed [VALUE_WIDTH-1:0] num_a,
  input  logic signed [VALUE_WIDTH-1:0] den_a,
  input  logic signed [VALUE_WIDTH-1:0] num_b,
  input  logic signed [VALUE_WIDTH-1:0] den_b,
  output logic                          done,
  output logic signed [OUT_WIDTH-1:0]   result_num,
  output logic signed [OUT_WIDTH-1:0]   result_den,
  output logic [1:0]                    error_code
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 1;
  localparam int XW = (MW > OUT_WIDTH) ? MW : OUT_WIDTH;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? W'(~v + 1'b1) : v;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic neg,
                                                  input logic [MW-1:0] mag);
    logic [XW-1:0] e;
    e = XW'(mag);
    if (neg) e = XW'(~e + 1'b1);
    to_out = e[OUT_WIDTH-1:0];
  endfunction

  state_t state;
  state_t state_next;

  // Captured beat
  op_t          op_r;
  err_t         err_r;
  err_t         err_in;
  logic [W-1:0] na_mag, da_mag, nb_mag, db_mag;
  logic         na_neg, da_neg, nb_neg, db_neg;

  // Working values in sign and magnitude
  logic [MW-1:0] num_mag;
  logic          num_neg;
  logic [MW-1:0] den_mag;
  logic          den_neg;
  logic [PW-1:0] q_mag;
  logic          q_neg;
  logic [MW-1:0] g;

  // Shared multiplier
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic          mul_neg;
  logic [PW-1:0] prod;

  // Signed sum of the cross products
  logic [MW-1:0] q_ext;
  logic [MW-1:0] sum_mag;
  logic          sum_neg;

  // Unit handshakes
  logic          gcd_start;
  logic          gcd_done;
  logic [MW-1:0] gcd_g;
  logic          div_start;
  logic          div_done;
  logic [MW-1:0] div_dividend;
  logic [MW-1:0] div_q;

  // Classify the incoming beat
  always_comb begin
    if (den_a == '0 || den_b == '0) begin
      err_in = ERR_ZERO_DEN;
    end else if (op_t'(operation) == OP_DIV && num_b == '0) begin
      err_in = ERR_DIV_ZERO;
    end else begin
      err_in = ERR_OK;
    end
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    q_ext = MW'(q_mag);
    if (num_neg == q_neg) begin
      sum_mag = num_mag + q_ext;
      sum_neg = num_neg;
    end else if (num_mag >= q_ext) begin
      sum_mag = num_mag - q_ext;
      sum_neg = num_neg;
    end else begin
      sum_mag = q_ext - num_mag;
      sum_neg = q_neg;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = (err_in != ERR_OK) ? S_DONE : S_MUL0;
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: begin
        state_next = (op_r == OP_ADD || op_r == OP_SUB) ? S_MUL2 : S_GCD_GO;
      end
      S_MUL2:     state_next = S_SUM;
      S_SUM:      state_next = S_GCD_GO;
      S_GCD_GO:   state_next = S_GCD_WAIT;
      S_GCD_WAIT: begin
        if (gcd_done) state_next = S_DIVN_GO;
      end
      S_DIVN_GO:   state_next = S_DIVN_WAIT;
      S_DIVN_WAIT: begin
        if (div_done) state_next = S_DIVD_GO;
      end
      S_DIVD_GO:   state_next = S_DIVD_WAIT;
      S_DIVD_WAIT: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and unit controls
  always_comb begin
    busy         = (state != S_IDLE);
    done         = (state == S_DONE);
    result_num   = to_out(num_neg, num_mag);
    result_den   = to_out(den_neg, den_mag);
    error_code   = err_r;
    mul_a        = '0;
    mul_b        = '0;
    mul_neg      = 1'b0;
    gcd_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = num_mag;
    case (state)
      S_MUL0: begin
        mul_a   = na_mag;
        mul_b   = (op_r == OP_MUL) ? nb_mag : db_mag;
        mul_neg = na_neg ^ ((op_r == OP_MUL) ? nb_neg : db_neg);
      end
      S_MUL1: begin
        mul_a   = da_mag;
        mul_b   = (op_r == OP_DIV) ? nb_mag : db_mag;
        mul_neg = da_neg ^ ((op_r == OP_DIV) ? nb_neg : db_neg);
      end
      S_MUL2: begin
        mul_a   = nb_mag;
        mul_b   = da_mag;
        mul_neg = nb_neg ^ da_neg ^ (op_r == OP_SUB);
      end
      S_GCD_GO:  gcd_start = 1'b1;
      S_DIVN_GO: div_start = 1'b1;
      S_DIVD_GO: begin
        div_start    = 1'b1;
        div_dividend = den_mag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: capture, multiply, combine, reduce
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op_r    <= op_t'(operation);
          err_r   <= err_in;
          na_mag  <= mag_of(num_a);
          da_mag  <= mag_of(den_a);
          nb_mag  <= mag_of(num_b);
          db_mag  <= mag_of(den_b);
          na_neg  <= num_a[W-1];
          da_neg  <= den_a[W-1];
          nb_neg  <= num_b[W-1];
          db_neg  <= den_b[W-1];
          num_mag <= '0;
          num_neg <= 1'b0;
          den_mag <= '0;
          den_neg <= 1'b0;
        end
      end
      S_MUL0: begin
        num_mag <= MW'(prod);
        num_neg <= mul_neg && (prod != '0);
      end
      S_MUL1: begin
        den_mag <= MW'(prod);
        den_neg <= mul_neg && (prod != '0);
      end
      S_MUL2: begin
        q_mag <= prod;
        q_neg <= mul_neg && (prod != '0);
      end
      S_SUM: begin
        num_mag <= sum_mag;
        num_neg <= sum_neg;
      end
      S_GCD_WAIT: begin
        if (gcd_done) g <= gcd_g;
      end
      S_DIVN_WAIT: begin
        if (div_done) num_mag <= div_q;
      end
      S_DIVD_WAIT: begin
        if (div_done) den_mag <= div_q;
      end
      default: begin
      end
    endcase
  end

  rar_gcd #(
    .WIDTH (MW)
  ) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .x_in  (num_mag),
    .y_in  (den_mag),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rar_div #(
    .WIDTH (MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g),
    .done     (div_done),
    .quotient (div_q)
  );

  `RAR_ASSERT_NEXT(a_top_accept_busy, start && !busy, busy, "top: beat taken but not busy")
  `RAR_ASSERT_NEXT(a_top_done_single, done, !done, "top: result strobe held two cycles")
  `RAR_ASSERT_NOW(a_top_err_zero, done && error_code != ERR_OK, result_num == '0 && result_den == '0, "top: error result not zero")

endmodule
